// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

  // Default width of the input integer.
  localparam int DEF_VALUE_BITS = 32;

  // log10(2) scaled by 1e5, for the digit count of 2^(n-1).
  localparam int LOG10_2_SCALED = 30103;
  localparam int LOG10_SCALE    = 100000;

  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [3:0] CHAR_ZERO_HIGH = 4'h3;  // '0'..'9' are 0x30..0x39

  typedef logic [3:0] digit_t;

  // Operation applied to every digit cell in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

endpackage

// ===== rtl/sida_digit_cell.sv =====
// One BCD digit cell of the conversion chain: add-3 / shift step and digit shift-up.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_digit_cell
  import sida_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     carry_in,   // bit from the lower cell (or the magnitude MSB)
  input  digit_t   digit_in,   // lower cell's digit, used on shift-up
  output digit_t   digit,
  output logic     carry_out
);

  digit_t adj;

  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_CLEAR:  digit <= '0;
      CELL_DABBLE: digit <= {adj[2:0], carry_in};
      CELL_SHIFT:  digit <= digit_in;
      default:     digit <= digit;
    endcase
  end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Flow: a request is taken in IDLE, the magnitude passes through the add-3 chain,
// leading zero digits are trimmed, and then the characters go out.
// One number at a time: no new request is taken until the last character of the
// current number is accepted. The bit-serial add-3 pass over the digit cell chain
// takes one magnitude bit per cycle.
// Reset: synchronous, active high; returns to idle with no character pending.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // input request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  // output characters
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [7:0]            character,
  output logic                         last_char
);

  // Decimal digits of 2^(VALUE_BITS-1), the largest magnitude.
  localparam int NumDigits = ((VALUE_BITS - 1) * LOG10_2_SCALED) / LOG10_SCALE + 1;
  localparam int CntW      = $clog2(VALUE_BITS + 1);
  localparam int RemW      = $clog2(NumDigits + 1);

  // Flow: IDLE takes a request, CONV runs VALUE_BITS double-dabble steps through the
  // cell chain, TRIM shifts leading zero digits out the top, SIGN sends '-', and
  // DIGITS sends the top cell's digit and shifts the chain up once per character.
  typedef enum logic [2:0] {
    IDLE,
    CONV,
    TRIM,
    SIGN,
    DIGITS
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] mag;       // magnitude, MSB first into the chain
  logic                  neg;
  logic [CntW-1:0]       bit_cnt;   // conversion steps left
  logic [RemW-1:0]       rem;       // digits still in the chain to send

  cell_op_t              cell_op;
  digit_t                digits [NumDigits];
  logic   [NumDigits-1:0] carry;    // carry[i] feeds cell i
  digit_t                top_digit;

  logic in_acc;
  logic out_acc;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == SIGN) || (state == DIGITS);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign top_digit = digits[NumDigits-1];

  assign character = (state == SIGN) ? CHAR_MINUS : {CHAR_ZERO_HIGH, top_digit};
  assign last_char = (state == DIGITS) && (rem == RemW'(1));

  // Chain control: every cell gets the same operation each cycle.
  always_comb begin
    cell_op = CELL_HOLD;
    unique case (state)
      IDLE:    if (in_acc) cell_op = CELL_CLEAR;
      CONV:    cell_op = CELL_DABBLE;
      TRIM:    if (top_digit == '0 && rem > RemW'(1)) cell_op = CELL_SHIFT;
      DIGITS:  if (out_ready) cell_op = CELL_SHIFT;
      default: cell_op = CELL_HOLD;
    endcase
  end

  assign carry[0] = mag[VALUE_BITS-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i < NumDigits - 1) begin : g_mid
      sida_digit_cell u_cell (
        .clk       (clk),
        .op        (cell_op),
        .carry_in  (carry[i]),
        .digit_in  ((i == 0) ? digit_t'(0) : digits[(i == 0) ? 0 : i - 1]),
        .digit     (digits[i]),
        .carry_out (carry[i+1])
      );
    end else begin : g_top
      // Top cell never overflows: the chain is sized for the largest magnitude.
      sida_digit_cell u_cell (
        .clk       (clk),
        .op        (cell_op),
        .carry_in  (carry[i]),
        .digit_in  ((i == 0) ? digit_t'(0) : digits[(i == 0) ? 0 : i - 1]),
        .digit     (digits[i]),
        .carry_out ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      neg     <= 1'b0;
      bit_cnt <= '0;
      rem     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            neg     <= value[VALUE_BITS-1];
            // Most negative value negates to itself, which is its unsigned magnitude.
            mag     <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bit_cnt <= CntW'(VALUE_BITS);
            state   <= CONV;
          end
        end
        CONV: begin
          mag     <= mag << 1;
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CntW'(1)) begin
            rem   <= RemW'(NumDigits);
            state <= TRIM;
          end
        end
        TRIM: begin
          if (top_digit == '0 && rem > RemW'(1)) begin
            rem <= rem - 1'b1;
          end else begin
            state <= neg ? SIGN : DIGITS;
          end
        end
        SIGN: begin
          if (out_ready) state <= DIGITS;
        end
        DIGITS: begin
          if (out_ready) begin
            rem <= rem - 1'b1;
            if (rem == RemW'(1)) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sida_checker.sv =====
// Port-level checks for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_checker
  import sida_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] character,
  input logic       last_char
);

  // Stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_char))
    else $error("character changed while stalled");

  // One number at a time: no request taken while text is going out.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after request");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  (character >= 8'h30 && character <= 8'h39))
    else $error("character outside '-' and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && character == CHAR_MINUS |-> !last_char)
    else $error("minus sign flagged last");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
